/* src/cjat_pkg.sv */
// Shared types, constants and codes for the cron job alarm table.
package cjat_pkg;

  localparam int NUM_JOBS    = 16;
  localparam int JOB_IDX_W   = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int MODE_W    = 2;
  localparam int SLOT_W    = 4;
  localparam int MINUTE_W  = 7;
  localparam int HOUR_W    = 6;
  localparam int DAY_W     = 6;
  localparam int MONTH_W   = 5;
  localparam int WEEKDAY_W = 4;
  localparam int IVL_W     = 10;
  localparam int LIMIT_W   = 16;
  localparam int TIME_W    = 32;
  localparam int IVL_SEC_W = 16;

  localparam int SEC_PER_MIN = 60;
  localparam logic [LIMIT_W-1:0] RUN_COUNT_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_REMOVE,
    OP_TICK
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_FINISH
  } back_state_e;

  typedef struct packed {
    op_e                          op;
    logic [SLOT_W-1:0]            slot;
    logic signed [MINUTE_W-1:0]   minute;
    logic signed [HOUR_W-1:0]     hour;
    logic signed [DAY_W-1:0]      day;
    logic signed [MONTH_W-1:0]    month;
    logic signed [WEEKDAY_W-1:0]  weekday;
    logic [IVL_SEC_W-1:0]         ivl_secs;
    logic [LIMIT_W-1:0]           limit;
    logic [TIME_W-1:0]            now;
  } cmd_t;

endpackage

/* src/cjat_if.sv */
// Handshake interfaces for the input and result channels.
interface cjat_in_if;
  import cjat_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [MODE_W-1:0]            mode;
  logic [SLOT_W-1:0]            job_slot;
  logic signed [MINUTE_W-1:0]   minute_value;
  logic signed [HOUR_W-1:0]     hour_value;
  logic signed [DAY_W-1:0]      day_value;
  logic signed [MONTH_W-1:0]    month_value;
  logic signed [WEEKDAY_W-1:0]  weekday_value;
  logic [IVL_W-1:0]             period_minutes;
  logic [LIMIT_W-1:0]           repeat_limit;
  logic [TIME_W-1:0]            now_seconds;

  modport source (
    output valid, mode, job_slot, minute_value, hour_value, day_value, month_value,
           weekday_value, period_minutes, repeat_limit, now_seconds,
    input  ready
  );
  modport sink (
    input  valid, mode, job_slot, minute_value, hour_value, day_value, month_value,
           weekday_value, period_minutes, repeat_limit, now_seconds,
    output ready
  );
endinterface

interface cjat_out_if;
  import cjat_pkg::*;
  logic              valid;
  logic              ready;
  logic              fired;
  logic [SLOT_W-1:0] fired_slot;
  logic              deactivated;
  logic              last_in_tick;

  modport source (
    output valid, fired, fired_slot, deactivated, last_in_tick,
    input  ready
  );
  modport sink (
    input  valid, fired, fired_slot, deactivated, last_in_tick,
    output ready
  );
endinterface

/* src/cron_job_alarm_table_unit.sv */
// Top level of the cron job alarm table: front end, command queue and back end.
// Load and remove words are executed by the back end and produce no result.
// A tick walks every slot and ends with one result word flagged last_in_tick;
// the walk reads one table slot per cycle while a held firing can leave.
// Reset clears every slot's active bit, empties the queue and drops any pending result.
module cron_job_alarm_table_unit
  import cjat_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  cjat_in_if.sink    in_i,
  cjat_out_if.source out_o
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  cmd_t q_head;
  logic q_empty;

  cjat_front u_front (
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  cjat_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (q_head),
    .empty_o    (q_empty)
  );

  cjat_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

/* src/cjat_queue.sv */
// Short command queue between the front and the back of the alarm table.
module cjat_queue
  import cjat_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* src/cjat_front.sv */
// Front end: accepts input words, classifies them and feeds the command queue.
module cjat_front
  import cjat_pkg::*;
(
  cjat_in_if.sink in_i,
  input  logic    q_full_i,
  output logic    push_o,
  output cmd_t    push_cmd_o
);

  logic accept;
  logic keep;
  logic slot_ok;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign slot_ok    = (int'(in_i.job_slot) < NUM_JOBS);

  always_comb begin
    push_cmd_o.op       = OP_TICK;
    push_cmd_o.slot     = in_i.job_slot;
    push_cmd_o.minute   = in_i.minute_value;
    push_cmd_o.hour     = in_i.hour_value;
    push_cmd_o.day      = in_i.day_value;
    push_cmd_o.month    = in_i.month_value;
    push_cmd_o.weekday  = in_i.weekday_value;
    // The interval is kept in seconds so the walk needs only a compare.
    push_cmd_o.ivl_secs = IVL_SEC_W'(in_i.period_minutes) * IVL_SEC_W'(SEC_PER_MIN);
    push_cmd_o.limit    = in_i.repeat_limit;
    push_cmd_o.now      = in_i.now_seconds;
    keep                = 1'b0;
    unique case (in_i.mode)
      MODE_LOAD: begin
        push_cmd_o.op = OP_LOAD;
        keep          = slot_ok;
      end
      MODE_REMOVE: begin
        push_cmd_o.op = OP_REMOVE;
        keep          = slot_ok;
      end
      MODE_TICK: begin
        push_cmd_o.op = OP_TICK;
        keep          = 1'b1;
      end
      default: begin
        // The unused mode is consumed and produces nothing.
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = accept && keep;

endmodule

/* src/cjat_back.sv */
// Back end: holds the job table, executes commands and walks the slots on a tick.
module cjat_back
  import cjat_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  cmd_t       q_head_i,
  output logic       pop_o,
  cjat_out_if.source out_o
);

  // Job table.
  logic [NUM_JOBS-1:0]          active_q;
  logic                         has_run_q   [NUM_JOBS];
  logic [TIME_W-1:0]            last_fire_q [NUM_JOBS];
  logic [LIMIT_W-1:0]           run_count_q [NUM_JOBS];
  logic signed [MINUTE_W-1:0]   minute_q    [NUM_JOBS];
  logic signed [HOUR_W-1:0]     hour_q      [NUM_JOBS];
  logic signed [DAY_W-1:0]      day_q       [NUM_JOBS];
  logic signed [MONTH_W-1:0]    month_q     [NUM_JOBS];
  logic signed [WEEKDAY_W-1:0]  weekday_q   [NUM_JOBS];
  logic [IVL_SEC_W-1:0]         ivl_secs_q  [NUM_JOBS];
  logic [LIMIT_W-1:0]           limit_q     [NUM_JOBS];

  // Tick being walked.
  logic [TIME_W-1:0]            tick_now_q;
  logic signed [MINUTE_W-1:0]   tick_minute_q;
  logic signed [HOUR_W-1:0]     tick_hour_q;
  logic signed [DAY_W-1:0]      tick_day_q;
  logic signed [MONTH_W-1:0]    tick_month_q;
  logic signed [WEEKDAY_W-1:0]  tick_weekday_q;

  back_state_e          state_q, state_d;
  logic [JOB_IDX_W-1:0] idx_q, idx_d;
  logic                 pend_valid_q, pend_valid_d;
  logic [SLOT_W-1:0]    pend_slot_q, pend_slot_d;
  logic                 pend_deact_q, pend_deact_d;

  logic                 out_valid_q;
  logic                 out_fired_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic                 out_deact_q;
  logic                 out_last_q;

  logic                 ld_we, rm_we, fire_we, tick_ld;
  logic [JOB_IDX_W-1:0] cmd_idx;
  logic                 push;
  logic                 push_fired, push_deact, push_last;
  logic [SLOT_W-1:0]    push_slot;
  logic                 out_free;

  // Walk datapath for the slot at idx_q.
  logic [LIMIT_W-1:0]   cur_count, cur_limit, next_count;
  logic [TIME_W:0]      diff;
  logic                 not_earlier, ivl_reached, guard_ok;
  logic                 fields_match, eligible, fire, deact;

  assign cmd_idx   = JOB_IDX_W'(q_head_i.slot);
  assign out_free  = !out_valid_q || out_o.ready;
  assign cur_count = run_count_q[idx_q];
  assign cur_limit = limit_q[idx_q];

  assign diff        = {1'b0, tick_now_q} - {1'b0, last_fire_q[idx_q]};
  assign not_earlier = !diff[TIME_W];
  assign ivl_reached = not_earlier &&
                       (diff[TIME_W-1:0] >= TIME_W'(ivl_secs_q[idx_q]));
  assign guard_ok    = not_earlier && (diff[TIME_W-1:0] >= TIME_W'(SEC_PER_MIN));

  // A negative schedule field is a wildcard.
  assign fields_match = (minute_q[idx_q][MINUTE_W-1]   || minute_q[idx_q]  == tick_minute_q) &&
                        (hour_q[idx_q][HOUR_W-1]       || hour_q[idx_q]    == tick_hour_q) &&
                        (day_q[idx_q][DAY_W-1]         || day_q[idx_q]     == tick_day_q) &&
                        (month_q[idx_q][MONTH_W-1]     || month_q[idx_q]   == tick_month_q) &&
                        (weekday_q[idx_q][WEEKDAY_W-1] || weekday_q[idx_q] == tick_weekday_q);

  assign eligible = active_q[idx_q] && !((cur_limit != '0) && (cur_count >= cur_limit));

  always_comb begin
    if (ivl_secs_q[idx_q] != '0) begin
      fire = eligible && (!has_run_q[idx_q] || ivl_reached);
    end else begin
      fire = eligible && fields_match && (!has_run_q[idx_q] || guard_ok);
    end
  end

  assign next_count = (cur_count == RUN_COUNT_MAX) ? cur_count : cur_count + 1'b1;
  assign deact      = (cur_limit != '0) && (next_count >= cur_limit);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    pend_deact_d = pend_deact_q;
    pop_o        = 1'b0;
    ld_we        = 1'b0;
    rm_we        = 1'b0;
    fire_we      = 1'b0;
    tick_ld      = 1'b0;
    push         = 1'b0;
    push_fired   = 1'b0;
    push_slot    = '0;
    push_deact   = 1'b0;
    push_last    = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          unique case (q_head_i.op)
            OP_LOAD:   ld_we = 1'b1;
            OP_REMOVE: rm_we = 1'b1;
            OP_TICK: begin
              tick_ld      = 1'b1;
              idx_d        = '0;
              pend_valid_d = 1'b0;
              state_d      = BK_WALK;
            end
            default: ;
          endcase
        end
      end
      BK_WALK: begin
        // A firing slot is held back until the next firing or the end of the walk so the last
        // result of the tick can be flagged; the step stalls while that held word cannot leave.
        if (!(fire && pend_valid_q && !out_free)) begin
          if (fire) begin
            fire_we      = 1'b1;
            pend_valid_d = 1'b1;
            pend_slot_d  = SLOT_W'(idx_q);
            pend_deact_d = deact;
            if (pend_valid_q) begin
              push       = 1'b1;
              push_fired = 1'b1;
              push_slot  = pend_slot_q;
              push_deact = pend_deact_q;
            end
          end
          if (idx_q == JOB_IDX_W'(NUM_JOBS - 1)) begin
            state_d = BK_FINISH;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      BK_FINISH: begin
        if (out_free) begin
          push       = 1'b1;
          push_fired = pend_valid_q;
          push_slot  = pend_valid_q ? pend_slot_q : '0;
          push_deact = pend_valid_q && pend_deact_q;
          push_last  = 1'b1;
          state_d    = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      active_q     <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (ld_we) begin
        active_q[cmd_idx] <= 1'b1;
      end
      if (rm_we) begin
        active_q[cmd_idx] <= 1'b0;
      end
      if (fire_we && deact) begin
        active_q[idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q  <= pend_slot_d;
    pend_deact_q <= pend_deact_d;
    if (push) begin
      out_fired_q <= push_fired;
      out_slot_q  <= push_slot;
      out_deact_q <= push_deact;
      out_last_q  <= push_last;
    end
    if (tick_ld) begin
      tick_now_q     <= q_head_i.now;
      tick_minute_q  <= q_head_i.minute;
      tick_hour_q    <= q_head_i.hour;
      tick_day_q     <= q_head_i.day;
      tick_month_q   <= q_head_i.month;
      tick_weekday_q <= q_head_i.weekday;
    end
    if (ld_we) begin
      has_run_q[cmd_idx]   <= 1'b0;
      last_fire_q[cmd_idx] <= '0;
      run_count_q[cmd_idx] <= '0;
      minute_q[cmd_idx]    <= q_head_i.minute;
      hour_q[cmd_idx]      <= q_head_i.hour;
      day_q[cmd_idx]       <= q_head_i.day;
      month_q[cmd_idx]     <= q_head_i.month;
      weekday_q[cmd_idx]   <= q_head_i.weekday;
      ivl_secs_q[cmd_idx]  <= q_head_i.ivl_secs;
      limit_q[cmd_idx]     <= q_head_i.limit;
    end
    if (fire_we) begin
      has_run_q[idx_q]   <= 1'b1;
      last_fire_q[idx_q] <= tick_now_q;
      run_count_q[idx_q] <= next_count;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.fired        = out_fired_q;
  assign out_o.fired_slot   = out_slot_q;
  assign out_o.deactivated  = out_deact_q;
  assign out_o.last_in_tick = out_last_q;

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Testbench for the cron job alarm table: directed and random words, predicted firings checked in order.
module tb;
  import cjat_pkg::*;

  localparam int RANDOM_WORDS = 410;
  localparam int DRAIN_CYCLES = 4 * NUM_JOBS;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic                        calm;
    logic                        drain;
    logic [MODE_W-1:0]           mode;
    logic [SLOT_W-1:0]           slot;
    logic signed [MINUTE_W-1:0]  minute;
    logic signed [HOUR_W-1:0]    hour;
    logic signed [DAY_W-1:0]     day;
    logic signed [MONTH_W-1:0]   month;
    logic signed [WEEKDAY_W-1:0] weekday;
    logic [IVL_W-1:0]            ivl;
    logic [LIMIT_W-1:0]          limit;
    logic [TIME_W-1:0]           now;
  } job_word_t;

  typedef struct packed {
    logic              fired;
    logic [SLOT_W-1:0] slot;
    logic              deact;
    logic              last;
  } firing_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cjat_in_if  in_if ();
  cjat_out_if out_if ();

  cron_job_alarm_table_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predicted copy of the job table.
  logic                        tbl_active  [NUM_JOBS];
  logic                        tbl_has_run [NUM_JOBS];
  logic [TIME_W-1:0]           tbl_last    [NUM_JOBS];
  logic [LIMIT_W-1:0]          tbl_runs    [NUM_JOBS];
  logic signed [MINUTE_W-1:0]  tbl_min     [NUM_JOBS];
  logic signed [HOUR_W-1:0]    tbl_hour    [NUM_JOBS];
  logic signed [DAY_W-1:0]     tbl_day     [NUM_JOBS];
  logic signed [MONTH_W-1:0]   tbl_month   [NUM_JOBS];
  logic signed [WEEKDAY_W-1:0] tbl_wday    [NUM_JOBS];
  logic [IVL_W-1:0]            tbl_ivl     [NUM_JOBS];
  logic [LIMIT_W-1:0]          tbl_limit   [NUM_JOBS];

  job_word_t word_q[$];
  firing_t   firing_q[$];
  job_word_t drv_word;

  int words_total = 0;
  int words_taken = 0;
  int n_items     = 0;
  int err_cnt     = 0;
  int gap_left    = 0;
  int stall_left  = 0;
  int calm_left   = 0;
  logic calm_fill = 1'b0;

  // Schedules as loaded by the generator, used to aim ticks at a slot.
  int   gen_min [NUM_JOBS];
  int   gen_hour[NUM_JOBS];
  int   gen_day [NUM_JOBS];
  int   gen_mon [NUM_JOBS];
  int   gen_wday[NUM_JOBS];
  logic gen_loaded[NUM_JOBS];
  logic [TIME_W-1:0] gen_now;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int wide_rand(int w);
    int v;
    v = $urandom_range(0, (1 << w) - 1);
    if (v >= (1 << (w - 1))) v -= (1 << w);
    return v;
  endfunction

  // Schedule field: mostly wildcard or in range, now and then any value of the width.
  function automatic int rand_cal(int hi, int w);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return -1;
    if (r < 95) return $urandom_range(0, hi);
    return wide_rand(w);
  endfunction

  // Tick field that satisfies a schedule field, or a fresh value where it is a wildcard.
  function automatic int tick_field(int sched, int hi, int w);
    if (sched >= 0) return sched;
    if ($urandom_range(0, 9) != 0) return $urandom_range(0, hi);
    return wide_rand(w);
  endfunction

  function automatic bit cal_ok(int sched, int cur);
    return (sched < 0) || (sched == cur);
  endfunction

  function automatic void compute_firings(job_word_t w);
    firing_t f;
    int      i;
    int      n;
    bit      fire;
    longint  diff;
    n = 0;
    case (w.mode)
      MODE_LOAD: begin
        tbl_min[w.slot]     = w.minute;
        tbl_hour[w.slot]    = w.hour;
        tbl_day[w.slot]     = w.day;
        tbl_month[w.slot]   = w.month;
        tbl_wday[w.slot]    = w.weekday;
        tbl_ivl[w.slot]     = w.ivl;
        tbl_limit[w.slot]   = w.limit;
        tbl_has_run[w.slot] = 1'b0;
        tbl_last[w.slot]    = '0;
        tbl_runs[w.slot]    = '0;
        tbl_active[w.slot]  = 1'b1;
      end
      MODE_REMOVE: tbl_active[w.slot] = 1'b0;
      MODE_TICK: begin
        for (i = 0; i < NUM_JOBS; i++) begin
          if (tbl_active[i] && !(tbl_limit[i] != 0 && tbl_runs[i] >= tbl_limit[i])) begin
            diff = longint'(w.now) - longint'(tbl_last[i]);
            if (tbl_ivl[i] != 0) begin
              fire = !tbl_has_run[i] || (diff >= longint'(tbl_ivl[i]) * SEC_PER_MIN);
            end else begin
              fire = cal_ok(tbl_min[i], $signed(w.minute)) &&
                     cal_ok(tbl_hour[i], $signed(w.hour)) &&
                     cal_ok(tbl_day[i], $signed(w.day)) &&
                     cal_ok(tbl_month[i], $signed(w.month)) &&
                     cal_ok(tbl_wday[i], $signed(w.weekday));
              // A slot that has run must also wait a full minute since its last firing.
              if (fire && tbl_has_run[i] && diff < SEC_PER_MIN) fire = 1'b0;
            end
            if (fire) begin
              tbl_last[i]    = w.now;
              tbl_has_run[i] = 1'b1;
              if (tbl_runs[i] != RUN_COUNT_MAX) tbl_runs[i] = tbl_runs[i] + 1'b1;
              f.fired = 1'b1;
              f.slot  = SLOT_W'(i);
              f.deact = 1'b0;
              f.last  = 1'b0;
              if (tbl_limit[i] != 0 && tbl_runs[i] >= tbl_limit[i]) begin
                tbl_active[i] = 1'b0;
                f.deact       = 1'b1;
              end
              firing_q.push_back(f);
              n++;
            end
          end
        end
        if (n == 0) begin
          f = '0;
          f.last = 1'b1;
        end else begin
          f = firing_q.pop_back();
          f.last = 1'b1;
        end
        firing_q.push_back(f);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic check_firing();
    firing_t want;
    if (firing_q.size() == 0) begin
      report_mismatch("unexpected result word, fired_slot", out_if.fired_slot, 0);
    end else begin
      want = firing_q.pop_front();
      if (out_if.fired !== want.fired)
        report_mismatch("fired", out_if.fired, want.fired);
      if (out_if.fired_slot !== want.slot)
        report_mismatch("fired_slot", out_if.fired_slot, want.slot);
      if (out_if.deactivated !== want.deact)
        report_mismatch("deactivated", out_if.deactivated, want.deact);
      if (out_if.last_in_tick !== want.last)
        report_mismatch("last_in_tick", out_if.last_in_tick, want.last);
    end
  endtask

  task automatic push_word(logic [MODE_W-1:0] mode, int slot, int mi, int hr, int dy, int mo,
                           int wd, int ivl, int lim, logic [TIME_W-1:0] now);
    job_word_t w;
    w.calm    = calm_fill;
    w.drain   = 1'b0;
    w.mode    = mode;
    w.slot    = SLOT_W'(slot);
    w.minute  = MINUTE_W'(mi);
    w.hour    = HOUR_W'(hr);
    w.day     = DAY_W'(dy);
    w.month   = MONTH_W'(mo);
    w.weekday = WEEKDAY_W'(wd);
    w.ivl     = IVL_W'(ivl);
    w.limit   = LIMIT_W'(lim);
    w.now     = now;
    word_q.push_back(w);
    words_total++;
    if (mode != MODE_UNUSED) n_items++;
  endtask

  task automatic push_load(int slot, int mi, int hr, int dy, int mo, int wd, int ivl, int lim);
    gen_min[slot]    = mi;
    gen_hour[slot]   = hr;
    gen_day[slot]    = dy;
    gen_mon[slot]    = mo;
    gen_wday[slot]   = wd;
    gen_loaded[slot] = 1'b1;
    push_word(MODE_LOAD, slot, mi, hr, dy, mo, wd, ivl, lim, $urandom());
  endtask

  task automatic push_remove(int slot);
    gen_loaded[slot] = 1'b0;
    push_word(MODE_REMOVE, slot, wide_rand(MINUTE_W), wide_rand(HOUR_W), wide_rand(DAY_W),
              wide_rand(MONTH_W), wide_rand(WEEKDAY_W), $urandom_range(0, 1023),
              $urandom_range(0, 65535), $urandom());
  endtask

  task automatic push_tick(logic [TIME_W-1:0] now, int mi, int hr, int dy, int mo, int wd);
    push_word(MODE_TICK, $urandom_range(0, NUM_JOBS - 1), mi, hr, dy, mo, wd,
              $urandom_range(0, 1023), $urandom_range(0, 65535), now);
  endtask

  // Marker that holds the sender until every predicted firing has been seen.
  task automatic push_drain();
    job_word_t w;
    w = '0;
    w.drain = 1'b1;
    word_q.push_back(w);
  endtask

  task automatic advance_clock();
    int k;
    k = $urandom_range(0, 99);
    if (k < 80)      gen_now += $urandom_range(20, 200);
    else if (k < 92) gen_now -= $urandom_range(0, 100);
    else if (k < 98) gen_now += $urandom_range(0, 70000);
    else             gen_now = $urandom();
  endtask

  // Sender.
  always @(posedge clk_i) begin
    logic nxt_valid;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        compute_firings(drv_word);
        words_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          while (word_q.size() > 0 && word_q[0].drain && firing_q.size() == 0)
            void'(word_q.pop_front());
          if (word_q.size() > 0 && !word_q[0].drain) begin
            drv_word = word_q.pop_front();
            in_if.mode           <= drv_word.mode;
            in_if.job_slot       <= drv_word.slot;
            in_if.minute_value   <= drv_word.minute;
            in_if.hour_value     <= drv_word.hour;
            in_if.day_value      <= drv_word.day;
            in_if.month_value    <= drv_word.month;
            in_if.weekday_value  <= drv_word.weekday;
            in_if.period_minutes <= drv_word.ivl;
            in_if.repeat_limit   <= drv_word.limit;
            in_if.now_seconds    <= drv_word.now;
            nxt_valid = 1'b1;
            gap_left  = drv_word.calm ? 0 : pick_gap();
          end
        end
        in_if.valid <= nxt_valid;
      end
    end
  end

  // Receiver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_firing();
      if (calm_left > 0) begin
        calm_left--;
        out_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        calm_left = $urandom_range(40, 150);
        out_if.ready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_if.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int s;
    int j;
    int k;
    int nl;
    int nt;
    int tgt;
    int ivl;
    int lim;

    in_if.valid          = 1'b0;
    in_if.mode           = '0;
    in_if.job_slot       = '0;
    in_if.minute_value   = '0;
    in_if.hour_value     = '0;
    in_if.day_value      = '0;
    in_if.month_value    = '0;
    in_if.weekday_value  = '0;
    in_if.period_minutes = '0;
    in_if.repeat_limit   = '0;
    in_if.now_seconds    = '0;
    out_if.ready         = 1'b0;
    for (s = 0; s < NUM_JOBS; s++) begin
      tbl_active[s] = 1'b0;
      gen_loaded[s] = 1'b0;
    end

    // Directed words.
    calm_fill = 1'b1;
    gen_now   = 32'd100000;
    push_tick(gen_now, 0, 0, 1, 1, 0);            // empty table gives a quiet tick
    push_load(0, -1, -1, -1, -1, -1, 0, 0);
    push_load(15, 59, 23, 31, 12, 6, 1023, 1);
    push_load(5, 59, 23, 31, 12, 6, 0, 2);
    push_load(7, 0, 0, 1, 1, 0, 1, 0);
    push_tick(32'd100000, 59, 23, 31, 12, 6);
    push_tick(32'd100030, 59, 23, 31, 12, 6);     // inside the one-minute guard
    push_tick(32'd100060, 59, 23, 31, 12, 6);     // slot 5 reaches its limit
    push_tick(32'd99000, 59, 23, 31, 12, 6);      // time went backwards
    push_remove(0);
    push_word(MODE_UNUSED, 3, 5, 5, 5, 5, 5, 5, 5, 32'd100100);
    push_tick(32'd100200, 0, 0, 1, 1, 0);
    push_load(9, 63, 31, 31, 15, 7, 0, 65535);    // calendar values beyond their ranges
    push_load(3, -64, -32, -32, -16, -8, 0, 1);   // most negative values act as wildcards
    push_tick(32'd100300, 63, 31, 31, 15, 7);
    push_tick(32'hFFFF_FFFF, -64, -32, -32, -16, -8);
    push_load(12, 0, 0, 0, 0, 0, 1023, 0);
    push_tick(32'd0, 1, 1, 1, 1, 1);
    push_tick(32'd61380, 1, 1, 1, 1, 1);          // exactly one long interval later
    push_drain();
    push_remove(15);
    push_tick(32'd200000, 59, 23, 31, 12, 6);
    gen_now   = 32'd300000;

    // Random phases.
    while (n_items < RANDOM_WORDS) begin
      calm_fill = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // Every slot armed with a wildcard schedule, so a tick can fire all of them.
        for (s = 0; s < NUM_JOBS; s++)
          push_load(s, -1, -1, -1, -1, -1, $urandom_range(0, 1), $urandom_range(0, 3));
        for (j = 0; j < 3; j++) begin
          gen_now += $urandom_range(60, 120);
          push_tick(gen_now, tick_field(-1, 59, MINUTE_W), tick_field(-1, 23, HOUR_W),
                    tick_field(-1, 31, DAY_W), tick_field(-1, 12, MONTH_W),
                    tick_field(-1, 6, WEEKDAY_W));
        end
      end else begin
        nl = $urandom_range(1, 4);
        for (j = 0; j < nl; j++) begin
          s   = $urandom_range(0, NUM_JOBS - 1);
          k   = $urandom_range(0, 9);
          ivl = (k < 5) ? 0 : (k < 9) ? $urandom_range(1, 3) : $urandom_range(0, 1023);
          k   = $urandom_range(0, 9);
          lim = (k < 4) ? 0 : (k < 9) ? $urandom_range(1, 4) : $urandom_range(0, 65535);
          push_load(s, rand_cal(59, MINUTE_W), rand_cal(23, HOUR_W), rand_cal(31, DAY_W),
                    rand_cal(12, MONTH_W), rand_cal(6, WEEKDAY_W), ivl, lim);
        end
        nt = $urandom_range(2, 8);
        for (j = 0; j < nt; j++) begin
          advance_clock();
          tgt = $urandom_range(0, NUM_JOBS - 1);
          if ($urandom_range(0, 9) < 7 && gen_loaded[tgt])
            push_tick(gen_now, tick_field(gen_min[tgt], 59, MINUTE_W),
                      tick_field(gen_hour[tgt], 23, HOUR_W),
                      tick_field(gen_day[tgt], 31, DAY_W),
                      tick_field(gen_mon[tgt], 12, MONTH_W),
                      tick_field(gen_wday[tgt], 6, WEEKDAY_W));
          else
            push_tick(gen_now, tick_field(-1, 59, MINUTE_W), tick_field(-1, 23, HOUR_W),
                      tick_field(-1, 31, DAY_W), tick_field(-1, 12, MONTH_W),
                      tick_field(-1, 6, WEEKDAY_W));
          if ($urandom_range(0, 99) < 12) push_remove($urandom_range(0, NUM_JOBS - 1));
          if ($urandom_range(0, 99) < 3)
            push_word(MODE_UNUSED, $urandom_range(0, NUM_JOBS - 1), wide_rand(MINUTE_W),
                      wide_rand(HOUR_W), wide_rand(DAY_W), wide_rand(MONTH_W),
                      wide_rand(WEEKDAY_W), $urandom_range(0, 1023),
                      $urandom_range(0, 65535), $urandom());
        end
      end
      if ($urandom_range(0, 7) == 0) push_drain();
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_taken < words_total) @(negedge clk_i);
    while (firing_q.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (firing_q.size() > 0)
      report_mismatch("results never produced, count", 0, firing_q.size());

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
